// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the vector normalise unit.
// Depends on nothing; clock clk and reset arst_n are assumed by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, disabled during reset.
`define VN_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define VN_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/vn_pkg.sv =====
// Types and constants for the vector normalise unit.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package vn_pkg;

	localparam int unsigned CompW   = 32;   // component width
	localparam int unsigned SqW     = 64;   // sum of squares width
	localparam int unsigned RootW   = 32;   // length width
	localparam int unsigned QW      = 17;   // quotient width, up to 1.0
	localparam int unsigned NormW   = 17;   // min_norm width
	localparam int unsigned FracW   = 16;
	localparam logic [NormW-1:0] MinNormReset = 17'd1;

	// Per item side data travelling alongside the arithmetic cells
	typedef struct packed {
		logic [CompW-1:0] x;
		logic [CompW-1:0] y;
		logic [CompW-1:0] mx;
		logic [CompW-1:0] my;
		logic             nx;
		logic             ny;
		logic             fail;
		logic [RootW-1:0] len;
	} pay_t;

endpackage

// ===== hw/rtl/vn_sqrt_cell.sv =====
// One digit cell of the square root chain: settles one bit of the root.
// Depends on vn_pkg.
`timescale 1ns / 1ps

module vn_sqrt_cell (
	input  logic                     clk,
	input  logic                     en,
	input  logic [vn_pkg::SqW-1:0]   rad_i,
	input  logic [vn_pkg::RootW:0]   rem_i,
	input  logic [vn_pkg::RootW-1:0] root_i,
	output logic [vn_pkg::SqW-1:0]   rad_q,
	output logic [vn_pkg::RootW:0]   rem_q,
	output logic [vn_pkg::RootW-1:0] root_q
);
	import vn_pkg::*;

	logic [RootW+2:0] rem_n;
	logic [RootW+2:0] trial;
	logic [RootW+2:0] diff;
	logic             ge;

	// bring down two radicand bits and try root*4+1
	always_comb begin
		rem_n = {rem_i, rad_i[SqW-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		ge    = rem_n >= trial;
		diff  = rem_n - trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad_i[SqW-3:0], 2'b00};
			rem_q  <= ge ? diff[RootW:0] : rem_n[RootW:0];
			root_q <= {root_i[RootW-2:0], ge};
		end
	end

endmodule

// ===== hw/rtl/vn_div_cell.sv =====
// One step cell of a restoring divider chain: settles one quotient bit.
// Depends on vn_pkg.
`timescale 1ns / 1ps

module vn_div_cell (
	input  logic                     clk,
	input  logic                     en,
	input  logic [vn_pkg::RootW-1:0] len_i,
	input  logic [vn_pkg::RootW-1:0] rem_i,
	input  logic [vn_pkg::QW-1:0]    dvd_i,
	input  logic [vn_pkg::QW-1:0]    q_i,
	output logic [vn_pkg::RootW-1:0] rem_q,
	output logic [vn_pkg::QW-1:0]    dvd_q,
	output logic [vn_pkg::QW-1:0]    q_q
);
	import vn_pkg::*;

	logic [RootW:0] rem2;
	logic [RootW:0] diff;
	logic           ge;

	// shift in next dividend bit, subtract divisor if it fits
	always_comb begin
		rem2 = {rem_i, dvd_i[QW-1]};
		ge   = rem2 >= {1'b0, len_i};
		diff = rem2 - {1'b0, len_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[RootW-1:0] : rem2[RootW-1:0];
			dvd_q <= {dvd_i[QW-2:0], 1'b0};
			q_q   <= {q_i[QW-2:0], ge};
		end
	end

endmodule

// ===== hw/rtl/vector_normalize_2d_unit.sv =====
// Top level of the 2-D vector normalise unit.
// Depends on vn_pkg, vn_sqrt_cell, vn_div_cell and assert_macros.svh.
//
// Usage:
//  s_* channel: one word per vector, s_tdata = {y_in, x_in}, signed Q16.16.
//  m_* channel: one word per result, m_tdata = {y_out, x_out}, m_tuser = ok.
//  cfg_* channel: writes min_norm (Q16.16, low 17 bits of cfg_data); only
//   write while the unit is empty. cfg_ready is always high.
//  Throughput: one vector per cycle while the output is not stalled.
//  Stages from input accept to m_tvalid: input register, square
//   multipliers, sum, 32 root digit cells, threshold compare, 17 divider
//   cells, output register. Root and divider cells form most of the stages.
//  Below min_norm (or zero length) the input passes through with ok = 0.
//  Stall: the whole pipeline freezes while m_tvalid is high and m_tready low;
//   s_tready then drops in the same cycle.
//  Reset: all valid flags clear, min_norm returns to 1 (2^-16).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vector_normalize_2d_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // x_in [31:0], y_in [63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // x_out [31:0], y_out [63:32]
	output logic [0:0]  m_tuser,   // ok [0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data   // min_norm
);
	import vn_pkg::*;

	localparam int unsigned SqrtN = RootW;
	localparam int unsigned DivN  = QW;
	localparam int unsigned StCmp = 3 + SqrtN;   // compare stage index
	localparam int unsigned NSt   = StCmp + 1 + DivN;

	logic             en;
	logic [NormW-1:0] min_norm_q;
	logic             vld_q [NSt];
	pay_t             pay_q [NSt];
	pay_t             pay_cmp;

	logic [SqW-1:0]   sqx_s2, sqy_s2, sum_s3;

	logic [SqW-1:0]   rad_c  [SqrtN+1];
	logic [RootW:0]   rem_c  [SqrtN+1];
	logic [RootW-1:0] root_c [SqrtN+1];

	logic [RootW-1:0] xr_c [DivN+1], yr_c [DivN+1];
	logic [QW-1:0]    xd_c [DivN+1], yd_c [DivN+1];
	logic [QW-1:0]    xq_c [DivN+1], yq_c [DivN+1];

	logic [CompW-1:0] xs, ys;
	logic [CompW-1:0] xq_ext, yq_ext;
	logic             fail_cmp;

	assign en        = m_tready | ~m_tvalid;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_norm_q <= MinNormReset;
		end else if (cfg_valid) begin
			min_norm_q <= cfg_data;
		end
	end

	// valid flags along the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSt; i++) vld_q[i] <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < NSt; i++) vld_q[i] <= vld_q[i-1];
			m_tvalid <= vld_q[NSt-1];
		end
	end

	assign xs = s_tdata[31:0];
	assign ys = s_tdata[63:32];
	assign fail_cmp = (root_c[SqrtN] == '0) ||
		({1'b0, root_c[SqrtN]} < {{(RootW+1-NormW){1'b0}}, min_norm_q});

	// side data entering the compare stage, with verdict and length
	always_comb begin
		pay_cmp      = pay_q[StCmp-1];
		pay_cmp.fail = fail_cmp;
		pay_cmp.len  = root_c[SqrtN];
	end

	// side data: magnitudes at entry, verdict at the compare stage
	always_ff @(posedge clk) begin
		if (en) begin
			pay_q[0].x    <= xs;
			pay_q[0].y    <= ys;
			pay_q[0].nx   <= xs[CompW-1];
			pay_q[0].ny   <= ys[CompW-1];
			pay_q[0].mx   <= xs[CompW-1] ? (~xs + 1'b1) : xs;
			pay_q[0].my   <= ys[CompW-1] ? (~ys + 1'b1) : ys;
			pay_q[0].fail <= 1'b0;
			pay_q[0].len  <= '0;
			for (int i = 1; i < NSt; i++) begin
				if (i == StCmp) begin
					pay_q[i] <= pay_cmp;
				end else begin
					pay_q[i] <= pay_q[i-1];
				end
			end
		end
	end

	// squares, then sum
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= pay_q[0].mx * pay_q[0].mx;
			sqy_s2 <= pay_q[0].my * pay_q[0].my;
			sum_s3 <= sqx_s2 + sqy_s2;
		end
	end

	// square root chain
	assign rad_c[0]  = sum_s3;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar g = 0; g < SqrtN; g++) begin : g_sqrt
		vn_sqrt_cell u_cell (
			.clk    (clk),
			.en     (en),
			.rad_i  (rad_c[g]),
			.rem_i  (rem_c[g]),
			.root_i (root_c[g]),
			.rad_q  (rad_c[g+1]),
			.rem_q  (rem_c[g+1]),
			.root_q (root_c[g+1])
		);
	end

	// divider chains, dividend m<<16 with partial remainder m>>1 preloaded
	always_ff @(posedge clk) begin
		if (en) begin
			xr_c[0] <= {1'b0, pay_q[StCmp-1].mx[CompW-1:1]};
			yr_c[0] <= {1'b0, pay_q[StCmp-1].my[CompW-1:1]};
			xd_c[0] <= {pay_q[StCmp-1].mx[0], {FracW{1'b0}}};
			yd_c[0] <= {pay_q[StCmp-1].my[0], {FracW{1'b0}}};
		end
	end
	assign xq_c[0] = '0;
	assign yq_c[0] = '0;

	for (genvar g = 0; g < DivN; g++) begin : g_div
		vn_div_cell u_xdiv (
			.clk   (clk),
			.en    (en),
			.len_i (pay_q[StCmp+g].len),
			.rem_i (xr_c[g]),
			.dvd_i (xd_c[g]),
			.q_i   (xq_c[g]),
			.rem_q (xr_c[g+1]),
			.dvd_q (xd_c[g+1]),
			.q_q   (xq_c[g+1])
		);
		vn_div_cell u_ydiv (
			.clk   (clk),
			.en    (en),
			.len_i (pay_q[StCmp+g].len),
			.rem_i (yr_c[g]),
			.dvd_i (yd_c[g]),
			.q_i   (yq_c[g]),
			.rem_q (yr_c[g+1]),
			.dvd_q (yd_c[g+1]),
			.q_q   (yq_c[g+1])
		);
	end

	// sign and select into the output register
	assign xq_ext = {{(CompW-QW){1'b0}}, xq_c[DivN]};
	assign yq_ext = {{(CompW-QW){1'b0}}, yq_c[DivN]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (pay_q[NSt-1].fail) begin
				m_tdata <= {pay_q[NSt-1].y, pay_q[NSt-1].x};
				m_tuser <= 1'b0;
			end else begin
				m_tdata <= {(pay_q[NSt-1].ny ? (~yq_ext + 1'b1) : yq_ext),
					(pay_q[NSt-1].nx ? (~xq_ext + 1'b1) : xq_ext)};
				m_tuser <= 1'b1;
			end
		end
	end

	`VN_ASSERT(a_x_range, (m_tvalid && m_tuser[0]) |-> ($signed(m_tdata[31:0]) <= 65536 && $signed(m_tdata[31:0]) >= -65536), "x_out beyond unit range")
	`VN_ASSERT(a_y_range, (m_tvalid && m_tuser[0]) |-> ($signed(m_tdata[63:32]) <= 65536 && $signed(m_tdata[63:32]) >= -65536), "y_out beyond unit range")
	`VN_ASSERT(a_ready, s_tready == (m_tready || !m_tvalid), "s_tready not tied to output stall")
	`VN_ASSERT(a_hold, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result changed while stalled")

endmodule

// ===== sim/tb_vector_normalize_2d_unit.sv =====
// Testbench for the 2-D vector normalise unit: stream stimulus with random idling,
// a Q16.16 length and quotient predictor and an in-order result checker.
// Depends on vn_pkg and vector_normalize_2d_unit.
`timescale 1ns / 1ps

module tb_vector_normalize_2d_unit;
	import vn_pkg::*;

	localparam int Latency = 54;
	localparam int WatchdogLimit = 20000;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        ok;
	} norm_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;

	norm_res_t   pending_norms[$];
	logic [16:0] min_len = MinNormReset;
	int          errors = 0;
	int          rx_idle_pct = 26;
	bit          rx_hold = 1'b0;
	int          quiet_cycles = 0;

	always #5 clk = ~clk;

	vector_normalize_2d_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Floor square root of a 64-bit value, digit by digit
	function automatic logic [31:0] floor_root(logic [63:0] s);
		logic [63:0] rem, root, b;
		rem = s;
		root = '0;
		b = 64'd1 << 62;
		while (b > rem)
			b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root[31:0];
	endfunction

	// Expected normalised vector for one input word
	function automatic norm_res_t normalise(logic [31:0] x, logic [31:0] y);
		norm_res_t r;
		logic [63:0] mx, my, len, qx, qy;
		mx = x[31] ? {32'd0, -x} : {32'd0, x};
		my = y[31] ? {32'd0, -y} : {32'd0, y};
		if (x == 32'h8000_0000) mx = 64'h8000_0000;
		if (y == 32'h8000_0000) my = 64'h8000_0000;
		len = {32'd0, floor_root(mx * mx + my * my)};
		if (len == 0 || len < {47'd0, min_len}) begin
			r.x = x;
			r.y = y;
			r.ok = 1'b0;
		end else begin
			qx = (mx << 16) / len;
			qy = (my << 16) / len;
			r.x = x[31] ? -qx[31:0] : qx[31:0];
			r.y = y[31] ? -qy[31:0] : qy[31:0];
			r.ok = 1'b1;
		end
		return r;
	endfunction

	// Receiver readiness with random idling or a forced hold-off
	always @(posedge clk) begin
		if (rx_hold)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Result checker
	always @(posedge clk) begin
		norm_res_t e;
		if (m_tvalid && m_tready) begin
			if (pending_norms.size() == 0) begin
				$display("%0t: unexpected word %h ok %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = pending_norms.pop_front();
				if (m_tdata[31:0] !== e.x) begin
					$display("%0t: x_out exp %h got %h", $time, e.x, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== e.y) begin
					$display("%0t: y_out exp %h got %h", $time, e.y, m_tdata[63:32]);
					errors++;
				end
				if (m_tuser[0] !== e.ok) begin
					$display("%0t: ok exp %b got %b", $time, e.ok, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no accepted word, paused during a forced hold-off
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rx_hold)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("** vector_normalize_2d_unit: FAILED **");
			$finish;
		end
	end

	// Send one vector; the valid stays high straight into the next word when no gap
	task automatic send_vec(logic [31:0] x, logic [31:0] y, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_norms.push_back(normalise(x, y));
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until all results are in, then let the pipeline drain
	task automatic drain();
		end_burst();
		while (pending_norms.size() != 0)
			@(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	task automatic write_min_len(logic [16:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		min_len = v;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(5))
			0: return $urandom_range(65536 * 2) - 65536;   // near unit size
			1: return $urandom_range(40) - 20;              // tiny
			2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
			3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Extremes, zero, signs and the length threshold
	task automatic test_directed();
		send_vec(32'h0, 32'h0, 0);
		send_vec(32'h8000_0000, 32'h8000_0000, 0);
		send_vec(32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_vec(32'h8000_0000, 32'h0, 0);
		send_vec(32'h0, 32'h7fff_ffff, 0);
		send_vec(32'h0001_0000, 32'h0, 0);
		send_vec(32'hffff_0000, 32'h0001_0000, 0);
		send_vec(32'h1, 32'h0, 0);
		send_vec(32'hffff_ffff, 32'hffff_ffff, 0);
		send_vec(32'h0003_0000, 32'hfffc_0000, 0);
		send_vec(32'h5555_5555, 32'haaaa_aaaa, 0);
		drain();
		// zero length with the minimum at zero
		write_min_len(17'd0);
		send_vec(32'h0, 32'h0, 0);
		send_vec(32'h1, 32'hffff_ffff, 0);
		drain();
		// threshold at one unit, just below and at it
		write_min_len(17'h10000);
		send_vec(32'h0000_ffff, 32'h0, 0);
		send_vec(32'h0001_0000, 32'h0, 0);
		send_vec(32'h0, 32'hffff_0000, 0);
		send_vec(32'h0000_b505, 32'h0000_b505, 0);
		send_vec(32'h0000_b504, 32'h0000_b504, 0);
		drain();
	endtask

	// Random vectors at one given length threshold
	task automatic test_random(int n, logic [16:0] thr);
		write_min_len(thr);
		for (int i = 0; i < n; i++)
			send_vec(rand_comp(), rand_comp(), 26);
		drain();
	endtask

	// Back-to-back with no idling on either side
	task automatic test_streaming();
		rx_idle_pct = 0;
		for (int i = 0; i < 150; i++)
			send_vec(rand_comp(), rand_comp(), 0);
		drain();
		rx_idle_pct = 26;
	endtask

	// Receiver held off so the pipeline fills and stalls the input
	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1'b1;
				repeat (200) @(posedge clk);
				rx_hold = 1'b0;
			end
			for (int i = 0; i < 120; i++)
				send_vec(rand_comp(), rand_comp(), 0);
		join
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150, MinNormReset);
		test_random(120, 17'h1ffff);
		test_random(120, 17'h0);
		test_streaming();
		test_backpressure();
		test_random(150, 17'($urandom_range(65536)));
		if (errors == 0)
			$display("** vector_normalize_2d_unit: PASSED **");
		else
			$display("** vector_normalize_2d_unit: FAILED **");
		$finish;
	end

endmodule
